FILE: src/rebd_pkg.sv
// shared constants for the rotary encoder and button decoder
`timescale 1ns / 1ps
`default_nettype none

package rebd_pkg;

  localparam logic       REQ_SAMPLE    = 1'b0;
  localparam logic       REQ_TICK      = 1'b1;

  localparam int         TIMER_W       = 16;
  localparam int         COUNT_W       = 8;
  localparam int         CREDIT_W      = 2;
  localparam int         CFG_DATA_W    = 32;
  localparam int         CFG_ADDR_W    = 3;

  localparam logic [TIMER_W-1:0]  HOLD_TIMEOUT_RST = 16'd1000;
  localparam logic [CREDIT_W-1:0] CREDIT_GRANT     = 2'd2;

  localparam logic       REG_HOLD_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [COUNT_W-1:0] position;
    logic               click_event;
    logic               hold_event;
  } result_t;

endpackage

`default_nettype wire

FILE: src/rotary_encoder_button_decoder_unit.sv
// rotary encoder and push button decoder: position count, click and hold detection
//
// channel  dir  handshake                 payload
// in_      in   in_valid / in_ready       req_type, btn_level, enc_a, enc_b
// out_     out  out_valid / out_ready     position, click_event, hold_event
// cfg_     in   apb psel/penable, pready  paddr[2:0], 32-bit data, reg 0 at 0x0
//
// one word per cycle unless the result stalls; the state update and result take a
// single pass of logic between the state registers and the result register
// a new word is taken whenever the result register is empty or being drained
// rst_n is synchronous: state returns to idle levels, timeout to 1000 ticks
// a stalled result holds its value and blocks input only while out_ready is low
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_button_decoder_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_req_type,
  input  wire logic                                in_btn_level,
  input  wire logic                                in_enc_a,
  input  wire logic                                in_enc_b,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [rebd_pkg::COUNT_W-1:0]             out_position,
  output logic                                     out_click_event,
  output logic                                     out_hold_event,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [rebd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [rebd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rebd_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);

  logic [rebd_pkg::TIMER_W-1:0]  hold_timeout_r;
  logic                          last_btn_r, last_btn_nxt;
  logic                          last_a_r, last_a_nxt;
  logic                          last_b_r, last_b_nxt;
  logic                          btn_armed_r, btn_armed_nxt;
  logic [rebd_pkg::CREDIT_W-1:0] edge_credit_r, edge_credit_nxt;
  logic [rebd_pkg::COUNT_W-1:0]  enc_count_r, enc_count_nxt;
  logic [rebd_pkg::TIMER_W-1:0]  hold_remaining_r, hold_remaining_nxt;
  logic                          hold_running_r, hold_running_nxt;
  logic                          out_valid_r;
  rebd_pkg::result_t             result_r, result_nxt;

  logic in_fire;
  logic cfg_write;
  logic cfg_sel_hold;

  assign in_ready     = !out_valid_r || out_ready;
  assign in_fire      = in_valid && in_ready;
  assign cfg_pready   = 1'b1;
  assign cfg_sel_hold = cfg_paddr[2] == rebd_pkg::REG_HOLD_TIMEOUT;
  assign cfg_write    = cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_hold;
  assign cfg_prdata   = cfg_sel_hold
                        ? {{(rebd_pkg::CFG_DATA_W-rebd_pkg::TIMER_W){1'b0}}, hold_timeout_r}
                        : '0;

  always_comb begin
    last_btn_nxt       = last_btn_r;
    last_a_nxt         = last_a_r;
    last_b_nxt         = last_b_r;
    btn_armed_nxt      = btn_armed_r;
    edge_credit_nxt    = edge_credit_r;
    enc_count_nxt      = enc_count_r;
    hold_remaining_nxt = hold_remaining_r;
    hold_running_nxt   = hold_running_r;
    result_nxt.click_event = 1'b0;
    result_nxt.hold_event  = 1'b0;

    if (in_req_type == rebd_pkg::REQ_SAMPLE) begin
      last_btn_nxt = in_btn_level;
      last_a_nxt   = in_enc_a;
      last_b_nxt   = in_enc_b;

      // button, active low
      if (in_btn_level != last_btn_r) begin
        if (in_btn_level) begin
          if (btn_armed_r) begin
            if (hold_running_r) begin
              hold_running_nxt       = 1'b0;
              hold_remaining_nxt     = '0;
              result_nxt.click_event = 1'b1;
            end
            btn_armed_nxt = 1'b0;
          end
        end else begin
          btn_armed_nxt      = 1'b1;
          hold_remaining_nxt = hold_timeout_r;
          hold_running_nxt   = 1'b1;
        end
      end

      // encoder credits and count
      if (in_enc_a != last_a_r) begin
        edge_credit_nxt = rebd_pkg::CREDIT_GRANT;
      end
      if (in_enc_b != last_b_r && edge_credit_nxt != '0) begin
        edge_credit_nxt = edge_credit_nxt - 1'b1;
        if (in_enc_a == in_enc_b) begin
          enc_count_nxt = enc_count_r + 1'b1;
        end else begin
          enc_count_nxt = enc_count_r - 1'b1;
        end
      end
    end else begin
      if (hold_running_r) begin
        if (hold_remaining_r <= rebd_pkg::TIMER_W'(1)) begin
          hold_running_nxt   = 1'b0;
          hold_remaining_nxt = '0;
          if (!last_btn_r && btn_armed_r) begin
            result_nxt.hold_event = 1'b1;
            btn_armed_nxt         = 1'b0;
          end
        end else begin
          hold_remaining_nxt = hold_remaining_r - 1'b1;
        end
      end
    end

    result_nxt.position = enc_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_timeout_r   <= rebd_pkg::HOLD_TIMEOUT_RST;
      last_btn_r       <= 1'b1;
      last_a_r         <= 1'b1;
      last_b_r         <= 1'b1;
      btn_armed_r      <= 1'b0;
      edge_credit_r    <= '0;
      enc_count_r      <= '0;
      hold_remaining_r <= '0;
      hold_running_r   <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_write) begin
        hold_timeout_r <= cfg_pwdata[rebd_pkg::TIMER_W-1:0];
      end
      if (in_fire) begin
        last_btn_r       <= last_btn_nxt;
        last_a_r         <= last_a_nxt;
        last_b_r         <= last_b_nxt;
        btn_armed_r      <= btn_armed_nxt;
        edge_credit_r    <= edge_credit_nxt;
        enc_count_r      <= enc_count_nxt;
        hold_remaining_r <= hold_remaining_nxt;
        hold_running_r   <= hold_running_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_position    = result_r.position;
  assign out_click_event = result_r.click_event;
  assign out_hold_event  = result_r.hold_event;

endmodule

`default_nettype wire

FILE: src/rebd_checker.sv
// port-level checks for the rotary encoder and button decoder
`timescale 1ns / 1ps
`default_nettype none

module rebd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [rebd_pkg::COUNT_W-1:0]    out_position,
  input wire logic                            out_click_event,
  input wire logic                            out_hold_event,
  input wire logic                            cfg_pready
);

  // no word appears out of reset
  a_idle_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result word present right after reset");

  // an accepted word shows up as a result the next cycle
  a_one_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // input is open whenever the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready && cfg_pready)
    else $error("input stalled with empty result register");

  // click and hold never come from the same word
  a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_click_event && out_hold_event))
    else $error("click and hold in one word");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position)
      && $stable(out_click_event) && $stable(out_hold_event))
    else $error("stalled result word changed");

endmodule

bind rotary_encoder_button_decoder_unit rebd_checker u_rebd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_position    (out_position),
  .out_click_event (out_click_event),
  .out_hold_event  (out_hold_event),
  .cfg_pready      (cfg_pready)
);

`default_nettype wire

FILE: test/tb_rotary_encoder_button_decoder_unit.sv
// testbench for the rotary encoder and button decoder: scoreboard class, drivers and checks
`timescale 1ns / 1ps

class encoder_scoreboard;
  logic [rebd_pkg::TIMER_W-1:0]  timeout;
  logic                          btn_prev;
  logic                          a_prev;
  logic                          b_prev;
  logic                          armed;
  logic                          timer_on;
  logic [rebd_pkg::TIMER_W-1:0]  timer_left;
  logic [rebd_pkg::CREDIT_W-1:0] credits;
  logic [rebd_pkg::COUNT_W-1:0]  count;
  rebd_pkg::result_t             due_reports[$];
  int                            errors;
  int                            words_seen;
  int                            reports_seen;
  int                            clicks;
  int                            holds;

  function new();
    timeout      = rebd_pkg::HOLD_TIMEOUT_RST;
    btn_prev     = 1'b1;
    a_prev       = 1'b1;
    b_prev       = 1'b1;
    armed        = 1'b0;
    timer_on     = 1'b0;
    timer_left   = '0;
    credits      = '0;
    count        = '0;
    errors       = 0;
    words_seen   = 0;
    reports_seen = 0;
    clicks       = 0;
    holds        = 0;
  endfunction

  function void set_timeout(logic [rebd_pkg::TIMER_W-1:0] value);
    timeout = value;
  endfunction

  function int pending();
    return due_reports.size();
  endfunction

  // update the decoder state for one accepted word and queue its report
  function void note_word(logic kind, logic btn, logic a, logic b);
    rebd_pkg::result_t r;
    logic    btn_chg;
    logic    a_chg;
    logic    b_chg;
    r = '0;
    words_seen++;
    if (kind == rebd_pkg::REQ_SAMPLE) begin
      btn_chg  = btn != btn_prev;
      a_chg    = a != a_prev;
      b_chg    = b != b_prev;
      btn_prev = btn;
      a_prev   = a;
      b_prev   = b;
      if (btn_chg) begin
        if (btn) begin
          if (armed) begin
            if (timer_on) begin
              timer_on      = 1'b0;
              timer_left    = '0;
              r.click_event = 1'b1;
            end
            armed = 1'b0;
          end
        end else begin
          armed      = 1'b1;
          timer_left = timeout;
          timer_on   = 1'b1;
        end
      end
      // credits from a are granted before b spends one
      if (a_chg) credits = rebd_pkg::CREDIT_GRANT;
      if (b_chg && credits != '0) begin
        credits = credits - 1'b1;
        if (a == b) count = count + 1'b1;
        else count = count - 1'b1;
      end
    end else if (timer_on) begin
      if (timer_left <= 1) begin
        timer_on   = 1'b0;
        timer_left = '0;
        if (!btn_prev && armed) begin
          r.hold_event = 1'b1;
          armed        = 1'b0;
        end
      end else begin
        timer_left = timer_left - 1'b1;
      end
    end
    r.position = count;
    clicks += r.click_event;
    holds  += r.hold_event;
    due_reports.push_back(r);
  endfunction

  function void check_result(logic [rebd_pkg::COUNT_W-1:0] position, logic click,
                             logic hold);
    rebd_pkg::result_t want;
    reports_seen++;
    if (due_reports.size() == 0) begin
      $error("result with nothing pending: position %0d click %0d hold %0d",
             position, click, hold);
      errors++;
      return;
    end
    want = due_reports.pop_front();
    if (position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, position);
      errors++;
    end
    if (click !== want.click_event) begin
      $error("click_event: expected %0d, got %0d", want.click_event, click);
      errors++;
    end
    if (hold !== want.hold_event) begin
      $error("hold_event: expected %0d, got %0d", want.hold_event, hold);
      errors++;
    end
  endfunction
endclass

module tb_rotary_encoder_button_decoder_unit;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int LONG_STALL    = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 66;
  localparam logic [rebd_pkg::CFG_ADDR_W-1:0] TIMEOUT_ADDR =
    rebd_pkg::CFG_ADDR_W'(4 * rebd_pkg::REG_HOLD_TIMEOUT);

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_req_type;
  logic                            in_btn_level;
  logic                            in_enc_a;
  logic                            in_enc_b;
  logic                            out_valid;
  logic                            out_ready;
  logic [rebd_pkg::COUNT_W-1:0]    out_position;
  logic                            out_click_event;
  logic                            out_hold_event;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [rebd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [rebd_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [rebd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  encoder_scoreboard sb;
  int   cycle_count = 0;
  int   settings_used = 0;
  bit   stall_on = 1'b1;
  bit   long_stall_req = 1'b0;
  logic cur_btn = 1'b1;
  logic cur_a = 1'b1;
  logic cur_b = 1'b1;

  rotary_encoder_button_decoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_btn_level   (in_btn_level),
    .in_enc_a       (in_enc_a),
    .in_enc_b       (in_enc_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_click_event(out_click_event),
    .out_hold_event (out_hold_event),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_position, out_click_event, out_hold_event);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  initial begin : ready_driver
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        out_ready <= 1'b1;
        long_stall_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic kind, logic btn, logic a, logic b);
    int gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_btn_level <= btn;
    in_enc_a     <= a;
    in_enc_b     <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_word(kind, btn, a, b);
    if (kind == rebd_pkg::REQ_SAMPLE) begin
      cur_btn = btn;
      cur_a   = a;
      cur_b   = b;
    end
    gap = (stall_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random_word();
    int         r;
    logic [1:0] g;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_word(rebd_pkg::REQ_TICK, 1'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      if ($urandom_range(0, 99) < 15) cur_btn = ~cur_btn;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // quadrature step along 00 01 11 10
        g = {cur_a, cur_a ^ cur_b};
        g = ($urandom_range(0, 1) != 0) ? g + 2'd1 : g - 2'd1;
        cur_a = g[1];
        cur_b = g[1] ^ g[0];
      end else if (r >= 85) begin
        cur_a = 1'($urandom);
        cur_b = 1'($urandom);
      end
      send_word(rebd_pkg::REQ_SAMPLE, cur_btn, cur_a, cur_b);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [rebd_pkg::TIMER_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TIMEOUT_ADDR;
    cfg_pwdata  <= {16'($urandom), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_timeout(value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [rebd_pkg::TIMER_W-1:0] tmo;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = rebd_pkg::REQ_SAMPLE;
    in_btn_level = 1'b1;
    in_enc_a     = 1'b1;
    in_enc_b     = 1'b1;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short click under the reset timeout
    send_word(rebd_pkg::REQ_SAMPLE, 1'b0, 1'b1, 1'b1);
    send_word(rebd_pkg::REQ_TICK,   1'b1, 1'b0, 1'b0);
    send_word(rebd_pkg::REQ_TICK,   1'b0, 1'b1, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b1, 1'b1);

    write_timeout(rebd_pkg::TIMER_W'(3));
    send_word(rebd_pkg::REQ_TICK,   1'b0, 1'b0, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b0, 1'b1, 1'b1);
    send_word(rebd_pkg::REQ_TICK,   1'b1, 1'b1, 1'b1);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b1, 1'b1);
    // press held past the timeout, then release with nothing armed
    send_word(rebd_pkg::REQ_SAMPLE, 1'b0, 1'b1, 1'b1);
    send_word(rebd_pkg::REQ_TICK,   1'b1, 1'b0, 1'b1);
    send_word(rebd_pkg::REQ_TICK,   1'b1, 1'b1, 1'b0);
    send_word(rebd_pkg::REQ_TICK,   1'b1, 1'b0, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b1, 1'b1);
    // encoder credits, no-credit b edge, both edges at once, wrap both ways
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b1);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b1);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b1, 1'b1);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b1, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b1);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b1, 1'b0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b1, 1'b1);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b0);
    // zero timeout acts like one tick
    write_timeout('0);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b0, 1'b0, 1'b0);
    send_word(rebd_pkg::REQ_TICK,   1'b1, 1'b1, 1'b1);
    send_word(rebd_pkg::REQ_SAMPLE, 1'b1, 1'b0, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       tmo = rebd_pkg::TIMER_W'(1);
        1:       tmo = '1;
        2:       tmo = rebd_pkg::TIMER_W'($urandom_range(2, 6));
        3:       tmo = rebd_pkg::TIMER_W'($urandom_range(1, 20));
        4:       tmo = rebd_pkg::TIMER_W'(2);
        default: tmo = rebd_pkg::TIMER_W'($urandom_range(3, 12));
      endcase
      write_timeout(tmo);
      if (ph == 1) begin
        // receiver holds off while words keep coming back to back
        stall_on = 1'b0;
        long_stall_req = 1'b1;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 40 == 39) stall_on = $urandom_range(0, 3) != 0;
        if (ph == 3 && i == PHASE_WORDS / 2) drain();
        send_random_word();
      end
      stall_on = 1'b1;
    end

    drain();
    $display("covered %0d words and %0d results over %0d timeout settings",
             sb.words_seen, sb.reports_seen, settings_used);
    $display("saw %0d clicks and %0d holds, final position %0d",
             sb.clicks, sb.holds, sb.count);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
